// ===== hw/rtl/rpp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpp_pkg
// Types, codes and defaults shared by the read placement and pileup block.
// ----------------------------------------------------------------------------
package rpp_pkg;

   localparam int REF_LEN_DEFAULT  = 512;
   localparam int READ_MAX_DEFAULT = 128;

   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_QUERY = 2'd2;
   localparam logic [1:0] KIND_SPARE = 2'd3;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_NO_MATCH = 2'd1;
   localparam logic [1:0] STAT_TOO_LONG = 2'd2;
   localparam logic [1:0] STAT_RANGE    = 2'd3;

   localparam logic RES_PLACE = 1'b0;
   localparam logic RES_QUERY = 1'b1;

   localparam logic REG_REF_LENGTH = 1'b0;
   localparam logic REG_COST_LIMIT = 1'b1;

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] base;
      logic [7:0] base_quality;
      logic       forward_strand;
      logic       last_base;
      logic       placement_given;
      logic [8:0] position;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [1:0]  status;
      logic [8:0]  placed_offset;
      logic [15:0] depth;
      logic [15:0] forward_count;
      logic [23:0] quality_total;
   } rsp_type;

   typedef struct packed {
      logic       forward;
      logic [7:0] quality;
      logic [1:0] base;
   } rbuf_type;

   typedef struct packed {
      logic       en;
      logic [1:0] base;
      logic [7:0] quality;
   } cell_wr_type;

   typedef struct packed {
      logic [15:0] count;
      logic [15:0] forward;
      logic [23:0] quality;
   } tally_type;

   typedef tally_type [3:0] tally_row_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SEARCH,
      ST_TALLY,
      ST_QUERY_REF,
      ST_QUERY_TALLY,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

// ===== hw/rtl/rpp_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpp_cell
// One scoring cell: holds one read base and adds its quality to the passing
// partial cost when it mismatches the broadcast reference base.
// ----------------------------------------------------------------------------
module rpp_cell #(
   parameter int INDEX = 0,
   parameter int IW    = 7,
   parameter int LW    = 8,
   parameter int SW    = 15
) (
   input  wire                  clock,
   input  wire                  reset,
   input  rpp_pkg::cell_wr_type wr,
   input  wire [IW-1:0]         wr_idx,
   input  wire [LW-1:0]         len,
   input  wire [1:0]            ref_base,
   input  wire                  sum_valid_in,
   input  wire [SW-1:0]         sum_in,
   output logic                 sum_valid_out,
   output logic [SW-1:0]        sum_out
);
   import rpp_pkg::*;

   logic [1:0]    base_ff;
   logic [7:0]    qual_ff;
   logic          valid_ff;
   logic [SW-1:0] sum_ff;
   logic [SW-1:0] sum_in_w;
   logic          mism;

   // cells past the read length add nothing
   assign mism     = (LW'(INDEX) < len) && (base_ff != ref_base);
   assign sum_in_w = sum_in + (mism ? SW'(qual_ff) : '0);

   always_ff @(posedge clock) begin
      if (wr.en && wr_idx == IW'(INDEX)) begin
         base_ff <= wr.base;
         qual_ff <= wr.quality;
      end
      sum_ff <= sum_in_w;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= sum_valid_in;
      end
   end

   assign sum_valid_out = valid_ff;
   assign sum_out       = sum_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/rpp_cell_row.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpp_cell_row
// Row of scoring cells; a partial cost enters cell 0 per offset and leaves
// the last cell complete, registered once in every cell on its way.
// ----------------------------------------------------------------------------
module rpp_cell_row #(
   parameter int READ_MAX = 128,
   parameter int IW       = 7,
   parameter int LW       = 8,
   parameter int SW       = 15
) (
   input  wire                  clock,
   input  wire                  reset,
   input  rpp_pkg::cell_wr_type wr,
   input  wire [IW-1:0]         wr_idx,
   input  wire [LW-1:0]         len,
   input  wire [1:0]            ref_base,
   input  wire                  inject,
   output logic                 cost_valid,
   output logic [SW-1:0]        cost
);
   import rpp_pkg::*;

   logic          vld_link [READ_MAX+1];
   logic [SW-1:0] sum_link [READ_MAX+1];

   assign vld_link[0] = inject;
   assign sum_link[0] = '0;

   for (genvar g = 0; g < READ_MAX; g++) begin : g_cell
      rpp_cell #(
         .INDEX(g),
         .IW   (IW),
         .LW   (LW),
         .SW   (SW)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .wr           (wr),
         .wr_idx       (wr_idx),
         .len          (len),
         .ref_base     (ref_base),
         .sum_valid_in (vld_link[g]),
         .sum_in       (sum_link[g]),
         .sum_valid_out(vld_link[g+1]),
         .sum_out      (sum_link[g+1])
      );
   end

   assign cost_valid = vld_link[READ_MAX];
   assign cost       = sum_link[READ_MAX];

endmodule
`default_nettype wire

// ===== hw/rtl/read_placement_and_pileup_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// read_placement_and_pileup_core
// Reference store, ungapped read placement and saturating pileup tallies.
// ----------------------------------------------------------------------------
// Usage:
//  req_* carries reference loads, read bases and queries; rsp_* returns one
//  item per closed read or query; registers ref_length and the cost limit sit
//  on the APB port at byte addresses 0 and 4.
//  Loads and read bases other than the last are taken one per cycle while the block is idle.
//  A searched read feeds its offsets through the cell row (one offset enters
//  per cycle, and each cost leaves the last cell complete), then updates the
//  tallies, one read-modify-write of the tally memory per base. A given
//  placement skips the search. A query reads the reference, then the tally,
//  then gives its result.
//  After reset a clearing pass zeroes every entry of the tally memory;
//  no item is taken during it, register writes are.
//  A finished result waits in the output register while the next items are
//  taken; a further result holds the block until the receiver takes the
//  waiting one.
// ----------------------------------------------------------------------------
module read_placement_and_pileup_core
   import rpp_pkg::*;
#(
   parameter int REF_LEN  = rpp_pkg::REF_LEN_DEFAULT,
   parameter int READ_MAX = rpp_pkg::READ_MAX_DEFAULT
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_ready,
   input  rpp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_ready,
   output rpp_pkg::rsp_type rsp_data,
   input  wire              psel,
   input  wire              penable,
   input  wire              pwrite,
   input  wire [2:0]        paddr,
   input  wire [31:0]       pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int AW     = (REF_LEN > 1) ? $clog2(REF_LEN) : 1;
   localparam int IW     = (READ_MAX > 1) ? $clog2(READ_MAX) : 1;
   localparam int LW     = $clog2(READ_MAX + 1);
   localparam int SW     = $clog2(READ_MAX * 255 + 1);
   localparam int SPAN_W = $clog2(REF_LEN + 1);
   localparam int OW     = (SPAN_W > 9) ? SPAN_W : 9;
   localparam int CW     = $clog2(REF_LEN + READ_MAX + 4);

   // memories
   logic [1:0]    ref_mem   [REF_LEN];
   rbuf_type      buf_mem   [READ_MAX];
   tally_row_type tally_mem [REF_LEN];
   logic [1:0]    ref_q;
   rbuf_type      buf_q;
   tally_row_type tally_q;

   state_type     state_ff, state_in;
   logic [9:0]    ref_length_ff;
   logic [15:0]   cost_limit_ff;
   logic [LW-1:0] len_ff, len_in;
   logic          ovf_ff, ovf_in;
   logic [LW-1:0] rlen_ff, rlen_in;
   logic [OW-1:0] off_ff, off_in;
   logic [CW-1:0] c_ff, c_in;
   logic          inj_ff, inj_in;
   logic [SW-1:0] best_ff, best_in;
   logic          have_ff, have_in;
   logic [OW-1:0] ocnt_ff, ocnt_in;
   logic [LW-1:0] ti_ff, ti_in;
   logic          p1_ff, p1_in, p2_ff;
   logic [AW-1:0] a1_ff, a1_in, a2_ff;
   rbuf_type      b2_ff;
   logic [AW-1:0] clr_ff, clr_in;
   logic [AW-1:0] qpos_ff, qpos_in;
   logic [1:0]    qbase_ff, qbase_in;
   rsp_type       res_ff, res_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          acc;
   logic [31:0]   span32;
   logic [31:0]   pos32;
   logic [31:0]   last_off32;
   logic [31:0]   len_n32;
   logic [LW-1:0] len_n;
   logic          ovf_n;
   logic          ref_we;
   logic          buf_we;
   logic [AW-1:0] ref_raddr;
   logic [AW-1:0] tally_raddr;
   logic          tally_we;
   logic [AW-1:0] tally_waddr;
   tally_row_type tally_wdata;
   tally_type     lane;
   tally_type     lane_upd;
   logic [24:0]   qsum;
   logic          issue;
   cell_wr_type   cell_wr;
   logic          cost_valid;
   logic [SW-1:0] cost;
   logic          csr_wr;

   // ---------------- configuration port ----------------
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;
   assign prdata = (paddr[2] == REG_COST_LIMIT) ? {16'b0, cost_limit_ff}
                                                : {22'b0, ref_length_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_length_ff <= '0;
         cost_limit_ff <= '0;
      end else if (csr_wr) begin
         if (paddr[2] == REG_REF_LENGTH) begin
            ref_length_ff <= pwdata[9:0];
         end else begin
            cost_limit_ff <= pwdata[15:0];
         end
      end
   end

   // ---------------- common terms ----------------
   assign span32     = ({22'b0, ref_length_ff} < 32'(REF_LEN)) ? {22'b0, ref_length_ff}
                                                               : 32'(REF_LEN);
   assign pos32      = {23'b0, req_data.position};
   assign last_off32 = span32 - 32'(rlen_ff);
   assign req_ready  = (state_ff == ST_IDLE);
   assign acc        = req_valid && req_ready;
   assign ovf_n      = ovf_ff || (32'(len_ff) >= 32'(READ_MAX));
   assign len_n      = ovf_n ? len_ff : len_ff + LW'(1);
   assign len_n32    = 32'(len_n);

   assign ref_we = acc && req_data.kind == KIND_LOAD && pos32 < 32'(REF_LEN);
   assign buf_we = acc && req_data.kind == KIND_READ && 32'(len_ff) < 32'(READ_MAX);

   assign cell_wr.en      = buf_we;
   assign cell_wr.base    = req_data.base;
   assign cell_wr.quality = req_data.base_quality;

   assign ref_raddr   = (state_ff == ST_SEARCH) ? AW'(c_ff) : AW'(req_data.position);
   assign tally_raddr = (state_ff == ST_QUERY_REF) ? qpos_ff : a1_ff;
   assign issue       = (state_ff == ST_TALLY) && (ti_ff < rlen_ff);

   // tally lane update for the base that completes this cycle
   assign lane = tally_q[b2_ff.base];
   assign qsum = {1'b0, lane.quality} + 25'(b2_ff.quality);
   always_comb begin
      lane_upd.count   = (lane.count != 16'hFFFF) ? lane.count + 16'd1 : lane.count;
      lane_upd.forward = (b2_ff.forward && lane.forward != 16'hFFFF) ? lane.forward + 16'd1
                                                                      : lane.forward;
      lane_upd.quality = qsum[24] ? 24'hFFFFFF : qsum[23:0];
      tally_wdata      = tally_q;
      tally_wdata[b2_ff.base] = lane_upd;
      tally_we         = 1'b0;
      tally_waddr      = a2_ff;
      if (state_ff == ST_CLEAR) begin
         tally_we    = 1'b1;
         tally_waddr = clr_ff;
         tally_wdata = '0;
      end else if (p2_ff) begin
         tally_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ref_we) begin
         ref_mem[AW'(req_data.position)] <= req_data.base;
      end
      ref_q <= ref_mem[ref_raddr];
      if (buf_we) begin
         buf_mem[IW'(len_ff)] <= '{forward: req_data.forward_strand,
                                   quality: req_data.base_quality,
                                   base:    req_data.base};
      end
      buf_q <= buf_mem[IW'(ti_ff)];
      if (tally_we) begin
         tally_mem[tally_waddr] <= tally_wdata;
      end
      tally_q <= tally_mem[tally_raddr];
   end

   // ---------------- scoring cells ----------------
   rpp_cell_row #(
      .READ_MAX(READ_MAX),
      .IW      (IW),
      .LW      (LW),
      .SW      (SW)
   ) u_row (
      .clock     (clock),
      .reset     (reset),
      .wr        (cell_wr),
      .wr_idx    (IW'(len_ff)),
      .len       (rlen_ff),
      .ref_base  (ref_q),
      .inject    (inj_ff),
      .cost_valid(cost_valid),
      .cost      (cost)
   );

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      len_in   = len_ff;
      ovf_in   = ovf_ff;
      rlen_in  = rlen_ff;
      off_in   = off_ff;
      c_in     = c_ff;
      inj_in   = 1'b0;
      best_in  = best_ff;
      have_in  = have_ff;
      ocnt_in  = ocnt_ff;
      ti_in    = ti_ff;
      p1_in    = 1'b0;
      a1_in    = a1_ff;
      clr_in   = clr_ff;
      qpos_in  = qpos_ff;
      qbase_in = qbase_ff;
      res_in   = res_ff;
      rsp_in   = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (32'(clr_ff) == 32'(REF_LEN - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (acc) begin
               case (req_data.kind)
                  KIND_READ: begin
                     len_in = len_n;
                     ovf_in = ovf_n;
                     if (req_data.last_base) begin
                        len_in  = '0;
                        ovf_in  = 1'b0;
                        rlen_in = len_n;
                        res_in  = '0;
                        res_in.result_kind = RES_PLACE;
                        off_in  = '0;
                        if (ovf_n || len_n32 > span32) begin
                           res_in.status = STAT_TOO_LONG;
                           state_in      = ST_DONE;
                        end else if (req_data.placement_given) begin
                           if (pos32 + len_n32 > span32) begin
                              res_in.status = STAT_RANGE;
                              state_in      = ST_DONE;
                           end else begin
                              off_in   = OW'(req_data.position);
                              ti_in    = '0;
                              state_in = ST_TALLY;
                           end
                        end else begin
                           c_in     = '0;
                           have_in  = 1'b0;
                           ocnt_in  = '0;
                           state_in = ST_SEARCH;
                        end
                     end
                  end
                  KIND_QUERY: begin
                     res_in = '0;
                     res_in.result_kind = RES_QUERY;
                     if (pos32 >= span32) begin
                        res_in.status = STAT_RANGE;
                        state_in      = ST_DONE;
                     end else begin
                        qpos_in  = AW'(req_data.position);
                        state_in = ST_QUERY_REF;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SEARCH: begin
            c_in   = c_ff + CW'(1);
            inj_in = 32'(c_ff) <= last_off32;
            if (cost_valid) begin
               // offsets leave the row in rising order: strict compare keeps the lowest
               if (!have_ff || cost < best_ff) begin
                  best_in = cost;
                  off_in  = ocnt_ff;
                  have_in = 1'b1;
               end
               ocnt_in = ocnt_ff + OW'(1);
            end
            if (32'(c_ff) == last_off32 + 32'(READ_MAX + 2)) begin
               if (have_ff && 32'(best_ff) <= {16'b0, cost_limit_ff}) begin
                  ti_in    = '0;
                  state_in = ST_TALLY;
               end else begin
                  res_in.status = STAT_NO_MATCH;
                  off_in        = '0;
                  state_in      = ST_DONE;
               end
            end
         end
         ST_TALLY: begin
            if (issue) begin
               a1_in = AW'(32'(off_ff) + 32'(ti_ff));
               ti_in = ti_ff + LW'(1);
               p1_in = 1'b1;
            end else if (!p1_ff && !p2_ff) begin
               res_in.status        = STAT_OK;
               res_in.placed_offset = off_ff[8:0];
               state_in             = ST_DONE;
            end
         end
         ST_QUERY_REF: begin
            qbase_in = ref_q;
            state_in = ST_QUERY_TALLY;
         end
         ST_QUERY_TALLY: begin
            res_in.status        = STAT_OK;
            res_in.depth         = tally_q[qbase_ff].count;
            res_in.forward_count = tally_q[qbase_ff].forward;
            res_in.quality_total = tally_q[qbase_ff].quality;
            state_in             = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      rlen_ff  <= rlen_in;
      off_ff   <= off_in;
      c_ff     <= c_in;
      best_ff  <= best_in;
      have_ff  <= have_in;
      ocnt_ff  <= ocnt_in;
      ti_ff    <= ti_in;
      a1_ff    <= a1_in;
      a2_ff    <= a1_ff;
      b2_ff    <= buf_q;
      qpos_ff  <= qpos_in;
      qbase_ff <= qbase_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         inj_ff       <= 1'b0;
         p1_ff        <= 1'b0;
         p2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         inj_ff       <= inj_in;
         p1_ff        <= p1_in;
         p2_ff        <= p1_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// ===== sim/read_placement_and_pileup_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// read_placement_and_pileup_checker
// Watches the request, response and register ports of the placement and
// pileup core, keeps its own copy of the reference, read buffer and tallies,
// and compares every response transfer with the oldest predicted one.
// ----------------------------------------------------------------------------
module read_placement_and_pileup_checker
   import rpp_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   input  wire     req_ready,
   input  req_type req_data,
   input  wire     rsp_valid,
   input  wire     rsp_ready,
   input  rsp_type rsp_data,
   input  wire     psel,
   input  wire     penable,
   input  wire     pwrite,
   input  wire [2:0]  paddr,
   input  wire [31:0] pwdata,
   input  wire     pready,
   output int      failures,
   output int      pending
);

   localparam int NREF  = REF_LEN_DEFAULT;
   localparam int NREAD = READ_MAX_DEFAULT;

   logic [1:0]  ref_bases [NREF];
   rbuf_type    read_bases [NREAD];
   int          read_len;
   bit          read_ovf;
   logic [15:0] depth_tally [NREF*4];
   logic [15:0] fwd_tally [NREF*4];
   logic [23:0] qual_tally [NREF*4];
   logic [9:0]  ref_length_q;
   logic [15:0] cost_limit_q;
   rsp_type     expected_rsp [$];

   assign pending = expected_rsp.size();

   task automatic predict_pileup(input req_type r);
      int span, len, off, cost, best, idx;
      bit have;
      logic [1:0] st;
      rsp_type e;
      span = (ref_length_q < NREF) ? int'(ref_length_q) : NREF;
      e = '0;
      case (r.kind)
         KIND_LOAD: begin
            ref_bases[r.position] = r.base;
         end
         KIND_READ: begin
            if (read_len < NREAD) begin
               read_bases[read_len] = '{forward: r.forward_strand, quality: r.base_quality,
                                        base: r.base};
               read_len++;
            end else begin
               read_ovf = 1'b1;
            end
            if (r.last_base) begin
               len = read_len;
               off = 0;
               st  = STAT_OK;
               if (read_ovf || len > span) begin
                  st = STAT_TOO_LONG;
               end else if (r.placement_given) begin
                  if (int'(r.position) + len > span) st = STAT_RANGE;
                  else off = r.position;
               end else begin
                  have = 1'b0;
                  best = 0;
                  for (int o = 0; o + len <= span; o++) begin
                     cost = 0;
                     for (int i = 0; i < len; i++)
                        if (read_bases[i].base != ref_bases[o+i]) cost += read_bases[i].quality;
                     if (!have || cost < best) begin
                        best = cost;
                        off  = o;
                        have = 1'b1;
                     end
                  end
                  if (!have || best > cost_limit_q) st = STAT_NO_MATCH;
               end
               if (st == STAT_OK) begin
                  for (int i = 0; i < len; i++) begin
                     idx = (off + i) * 4 + read_bases[i].base;
                     if (idx < NREF*4) begin
                        if (depth_tally[idx] != 16'hFFFF) depth_tally[idx]++;
                        if (read_bases[i].forward && fwd_tally[idx] != 16'hFFFF)
                           fwd_tally[idx]++;
                        if (int'(qual_tally[idx]) + int'(read_bases[i].quality) > 'hFFFFFF)
                           qual_tally[idx] = 24'hFFFFFF;
                        else
                           qual_tally[idx] = qual_tally[idx] + 24'(read_bases[i].quality);
                     end
                  end
               end else begin
                  off = 0;
               end
               read_len = 0;
               read_ovf = 1'b0;
               e.result_kind   = RES_PLACE;
               e.status        = st;
               e.placed_offset = off[8:0];
               expected_rsp.push_back(e);
            end
         end
         KIND_QUERY: begin
            e.result_kind = RES_QUERY;
            if (int'(r.position) >= span) begin
               e.status = STAT_RANGE;
            end else begin
               idx = r.position * 4 + ref_bases[r.position];
               e.status        = STAT_OK;
               e.depth         = depth_tally[idx];
               e.forward_count = fwd_tally[idx];
               e.quality_total = qual_tally[idx];
            end
            expected_rsp.push_back(e);
         end
         default: ;
      endcase
   endtask

   task automatic compare_rsp(input rsp_type a);
      rsp_type e;
      if (expected_rsp.size() == 0) begin
         $error("response transfer with nothing expected: %p", a);
         failures++;
         return;
      end
      e = expected_rsp.pop_front();
      if (a.result_kind !== e.result_kind) begin
         $error("result_kind expected %0d actual %0d", e.result_kind, a.result_kind);
         failures++;
      end
      if (a.status !== e.status) begin
         $error("status expected %0d actual %0d", e.status, a.status);
         failures++;
      end
      if (a.placed_offset !== e.placed_offset) begin
         $error("placed_offset expected %0d actual %0d", e.placed_offset, a.placed_offset);
         failures++;
      end
      if (a.depth !== e.depth) begin
         $error("depth expected %0d actual %0d", e.depth, a.depth);
         failures++;
      end
      if (a.forward_count !== e.forward_count) begin
         $error("forward_count expected %0d actual %0d", e.forward_count, a.forward_count);
         failures++;
      end
      if (a.quality_total !== e.quality_total) begin
         $error("quality_total expected %0d actual %0d", e.quality_total, a.quality_total);
         failures++;
      end
   endtask

   initial begin
      failures = 0;
      for (int i = 0; i < NREF*4; i++) begin
         depth_tally[i] = '0;
         fwd_tally[i]   = '0;
         qual_tally[i]  = '0;
      end
      for (int i = 0; i < NREF; i++) ref_bases[i] = '0;
   end

   always @(posedge clock) begin
      if (reset) begin
         read_len     = 0;
         read_ovf     = 1'b0;
         ref_length_q = '0;
         cost_limit_q = '0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr == {REG_REF_LENGTH, 2'b00}) ref_length_q = pwdata[9:0];
            else if (paddr == {REG_COST_LIMIT, 2'b00}) cost_limit_q = pwdata[15:0];
         end
         if (rsp_valid && rsp_ready) compare_rsp(rsp_data);
         if (req_valid && req_ready) predict_pileup(req_data);
      end
   end

endmodule

// ===== sim/read_placement_and_pileup_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// read_placement_and_pileup_core_tb
// Loads a full reference, then runs directed and random reads, loads and
// queries under several register settings with bursty requests and a
// stalling receiver; the checker beside the core scores every response.
// ----------------------------------------------------------------------------
module read_placement_and_pileup_core_tb;
   import rpp_pkg::*;

   localparam int NREF       = REF_LEN_DEFAULT;
   localparam int NREAD      = READ_MAX_DEFAULT;
   localparam int IDLE_LIMIT = 20000;
   localparam int SETTLE     = 1200;
   localparam int NPHASE     = 8;
   localparam int PHASE_ITEMS = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;
   int          failures;
   int          pending;

   logic [1:0]  model_ref [NREF];
   int          span_now;
   int          burst_left = 0;
   int          idle_cycles = 0;
   int          stall_left = 0;
   int          n_items = 0, n_reads = 0, n_queries = 0, n_loads = 0;

   always #6 clock = ~clock;

   read_placement_and_pileup_core i_dut (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   read_placement_and_pileup_checker i_checker (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
      .failures, .pending
   );

   // receiver: mostly ready, with occasional long stalls
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(1, 30);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_req(input req_type r);
      bit ok;
      req_valid <= 1'b1;
      req_data  <= r;
      do begin
         @(negedge clock);
         ok = req_ready;
         @(posedge clock);
      end while (!ok);
      n_items++;
      if (r.kind == KIND_LOAD) model_ref[r.position] = r.base;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 3) == 0 ? 60 : $urandom_range(1, 20);
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      bit ok;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(negedge clock);
         ok = pready;
         @(posedge clock);
      end while (!ok);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_regs(input int ref_len, input int cost_limit);
      drain_all();
      repeat (SETTLE) @(posedge clock);
      csr_write({REG_REF_LENGTH, 2'b00}, ref_len);
      csr_write({REG_COST_LIMIT, 2'b00}, cost_limit);
      span_now = ref_len < NREF ? ref_len : NREF;
   endtask

   // one read, bases copied from the reference at anchor with some mutations
   task automatic send_read(input int len, input bit given, input int pos, input int anchor);
      req_type r;
      for (int i = 0; i < len; i++) begin
         r.kind            = KIND_READ;
         r.base            = (anchor + i < NREF && $urandom_range(0, 4) != 0)
                             ? model_ref[anchor+i] : 2'($urandom);
         r.base_quality    = $urandom_range(0, 5) == 0 ? 8'hFF : 8'($urandom);
         r.forward_strand  = 1'($urandom);
         r.last_base       = (i == len - 1);
         r.placement_given = r.last_base ? given : 1'($urandom);
         r.position        = r.last_base ? 9'(pos) : 9'($urandom);
         send_req(r);
      end
      n_reads++;
   endtask

   task automatic send_simple(input logic [1:0] kind, input logic [1:0] base, input int pos);
      req_type r;
      r = req_type'($urandom);
      r.kind     = kind;
      r.base     = base;
      r.position = 9'(pos);
      send_req(r);
      if (kind == KIND_QUERY) n_queries++;
      if (kind == KIND_LOAD) n_loads++;
   endtask

   task automatic random_item();
      int w, len, pos, anchor;
      bit given;
      w = $urandom_range(0, 99);
      if (w < 8) begin
         send_simple(KIND_LOAD, 2'($urandom), $urandom_range(0, NREF - 1));
      end else if (w < 22) begin
         pos = (span_now > 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, span_now - 1)
                                                            : $urandom_range(0, NREF - 1);
         send_simple(KIND_QUERY, 2'($urandom), pos);
      end else if (w < 24) begin
         send_simple(KIND_SPARE, 2'($urandom), $urandom_range(0, NREF - 1));
      end else begin
         len = $urandom_range(0, 199) == 0 ? $urandom_range(NREAD + 1, NREAD + 4)
                                           : $urandom_range(1, 6);
         given = 1'($urandom);
         if (span_now >= len && $urandom_range(0, 4) != 0)
            anchor = $urandom_range(0, span_now - len);
         else
            anchor = $urandom_range(0, NREF - 1);
         pos = (given && $urandom_range(0, 4) == 0) ? $urandom_range(0, NREF - 1) : anchor;
         send_read(len, given, pos, anchor);
      end
   endtask

   initial begin
      int ref_lens [NPHASE];
      int costs [NPHASE];
      ref_lens = '{512, 0, 1, 20, 1023, 64, 600, 33};
      costs    = '{65535, 0, 0, 300, 65535, 1000, 0, 200};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < NREF; p++) send_simple(KIND_LOAD, 2'($urandom), p);
      set_regs(ref_lens[0], costs[0]);

      // directed: extremes, kinds and the edge cases of placement and query
      send_simple(KIND_QUERY, 2'd0, 0);
      send_simple(KIND_QUERY, 2'd3, NREF - 1);
      send_simple(KIND_LOAD, 2'd3, NREF - 1);
      send_read(1, 1'b1, NREF - 1, NREF - 1);
      send_simple(KIND_QUERY, 2'd0, NREF - 1);
      send_read(2, 1'b1, NREF - 1, NREF - 2);
      send_read(3, 1'b0, 0, 0);
      send_read(4, 1'b0, 0, 100);
      send_read(2, 1'b1, 0, 0);
      send_simple(KIND_SPARE, 2'd2, 7);
      send_simple(KIND_QUERY, 2'd1, 100);
      send_simple(KIND_QUERY, 2'd1, 0);

      for (int ph = 0; ph < NPHASE; ph++) begin
         if (ph > 0) set_regs(ref_lens[ph], costs[ph]);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            random_item();
            if (k == PHASE_ITEMS / 2) drain_all();
         end
      end
      // back to an empty reference span: every read too long, every query out of range
      set_regs(0, 65535);
      repeat (20) random_item();

      drain_all();
      repeat (SETTLE) @(posedge clock);
      $display("Covered %0d transfers: %0d reads, %0d queries, %0d loads over %0d settings.",
               n_items, n_reads, n_queries, n_loads, NPHASE + 2);
      if (failures == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== read_placement_and_pileup_core.f =====
hw/rtl/rpp_pkg.sv
hw/rtl/rpp_cell.sv
hw/rtl/rpp_cell_row.sv
hw/rtl/read_placement_and_pileup_core.sv
sim/read_placement_and_pileup_checker.sv
sim/read_placement_and_pileup_core_tb.sv
